// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the formatter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define TDSF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Property checked on every clock edge, reset included.
`define TDSF_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

// ----- src/tdsf_pkg.sv -----
// ----------------------------------------------------------------------------
// tdsf_pkg
// Types, constants and glyph functions of the three-digit segment formatter.
// ----------------------------------------------------------------------------
package tdsf_pkg;

    // Command codes.
    typedef enum logic [1:0] {
        OP_CHARS   = 2'd0,
        OP_NUMBER  = 2'd1,
        OP_SETTING = 2'd2,
        OP_REPEAT  = 2'd3
    } t_op;

    // Point position codes.
    localparam logic [1:0] PT_NONE   = 2'd0;
    localparam logic [1:0] PT_FIRST  = 2'd1;
    localparam logic [1:0] PT_SECOND = 2'd2;
    localparam logic [1:0] PT_THIRD  = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic CFG_IDX_LAYOUT   = 1'b0;
    localparam logic LAYOUT_RESET     = 1'b1;
    localparam int   PADDR_W          = 3;
    localparam int   PDATA_W          = 32;

    // Segment bits in the reversed-layout byte (top bar in the LSB).
    localparam logic [7:0] S_TOP = 8'h01;
    localparam logic [7:0] S_TR  = 8'h02;
    localparam logic [7:0] S_BR  = 8'h04;
    localparam logic [7:0] S_BOT = 8'h08;
    localparam logic [7:0] S_BL  = 8'h10;
    localparam logic [7:0] S_TL  = 8'h20;
    localparam logic [7:0] S_CEN = 8'h40;
    localparam logic [7:0] S_DP  = 8'h80;

    // Character codes used by the formatter itself.
    localparam logic [7:0] CODE_BLANK = 8'd32;
    localparam logic [7:0] CODE_MINUS = 8'd45;
    localparam logic [7:0] CODE_ZERO  = 8'd48;
    localparam logic [7:0] CODE_E     = 8'd69;
    localparam logic [7:0] CODE_R     = 8'd114;

    // Reciprocals for exact division of values up to 32768 by 10, 100, 1000.
    localparam logic [16:0] RECIP10    = 17'd52429;
    localparam int          SHIFT10    = 19;
    localparam logic [14:0] RECIP100   = 15'd20972;
    localparam int          SHIFT100   = 21;
    localparam logic [15:0] RECIP1000  = 16'd33555;
    localparam int          SHIFT1000  = 25;

    // Map a character code or raw digit value to its segment pattern.
    function automatic logic [7:0] glyph(input logic [7:0] code);
        logic [7:0] g;
        case (code)
            8'd0, "0", "O":      g = S_TOP | S_TR | S_BR | S_BOT | S_BL | S_TL;
            8'd1, "1", "i", "I": g = S_TR | S_BR;
            8'd2, "2":           g = S_TOP | S_TR | S_BOT | S_BL | S_CEN;
            8'd3, "3":           g = S_TOP | S_TR | S_BR | S_BOT | S_CEN;
            8'd4, "4":           g = S_CEN | S_TL | S_TR | S_BR;
            8'd5, "5", "s", "S": g = S_TOP | S_CEN | S_BOT | S_TL | S_BR;
            8'd6, "6":           g = S_TOP | S_CEN | S_BOT | S_TL | S_BL | S_BR;
            8'd7, "7":           g = S_TOP | S_TR | S_BR;
            8'd8, "8":           g = S_TOP | S_CEN | S_BOT | S_TL | S_TR | S_BL | S_BR;
            8'd9, "9":           g = S_TOP | S_CEN | S_TL | S_TR | S_BR;
            8'd10, ".":          g = S_DP;
            "_":                 g = S_BOT;
            "-":                 g = S_CEN;
            "=":                 g = S_BOT | S_CEN;
            "o":                 g = S_BR | S_BOT | S_BL | S_CEN;
            "A", "a":            g = S_TOP | S_TR | S_TL | S_BR | S_BL | S_CEN;
            "B", "b":            g = S_BR | S_BOT | S_BL | S_TL | S_CEN;
            "C", "c":            g = S_TOP | S_BOT | S_BL | S_TL;
            "D", "d":            g = S_TR | S_BR | S_BOT | S_BL | S_CEN;
            "E", "e":            g = S_TOP | S_BOT | S_BL | S_TL | S_CEN;
            "F", "f":            g = S_TOP | S_BL | S_TL | S_CEN;
            "G":                 g = S_TOP | S_BR | S_BOT | S_BL | S_TL;
            "g":                 g = S_TOP | S_TR | S_BR | S_BOT | S_BL | S_CEN;
            "!":                 g = S_TR | S_DP;
            "P", "p":            g = S_TOP | S_TR | S_BL | S_TL | S_CEN;
            "H":                 g = S_TR | S_BR | S_BL | S_TL | S_CEN;
            "h":                 g = S_BR | S_BL | S_TL | S_CEN;
            "L":                 g = S_BOT | S_TL | S_BL;
            "t", "T":            g = S_CEN | S_BOT | S_TL | S_BL;
            "r":                 g = S_CEN | S_BL;
            "V", "U":            g = S_BOT | S_BL | S_BR | S_TL | S_TR;
            "v", "u":            g = S_BOT | S_BL | S_BR;
            "#":                 g = 8'hFF;
            default:             g = 8'h00;
        endcase
        return g;
    endfunction

    // Bit reversal of one segment byte, for the top-bar-MSB wiring.
    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = v[k];
        end
        return r;
    endfunction

endpackage

// ----- src/tdsf_cmd_if.sv -----
// ----------------------------------------------------------------------------
// tdsf_cmd_if
// Command channel of the formatter: valid/ready plus one command.
// ----------------------------------------------------------------------------
interface tdsf_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [7:0]         char_a;
    logic [7:0]         char_b;
    logic [7:0]         char_c;
    logic signed [15:0] number;
    logic               zero_pad;
    logic [1:0]         point_position;

    modport source (
        output valid, operation, char_a, char_b, char_c, number, zero_pad,
               point_position,
        input  ready
    );

    modport sink (
        input  valid, operation, char_a, char_b, char_c, number, zero_pad,
               point_position,
        output ready
    );
endinterface

// ----- src/tdsf_seg_if.sv -----
// ----------------------------------------------------------------------------
// tdsf_seg_if
// Result channel of the formatter: valid/ready plus three segment bytes.
// ----------------------------------------------------------------------------
interface tdsf_seg_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_shifted;
    logic [7:0] second_shifted;
    logic [7:0] third_shifted;

    modport source (
        output valid, first_shifted, second_shifted, third_shifted,
        input  ready
    );

    modport sink (
        input  valid, first_shifted, second_shifted, third_shifted,
        output ready
    );
endinterface

// ----- src/three_digit_seven_segment_formatter_core.sv -----
// ----------------------------------------------------------------------------
// three_digit_seven_segment_formatter_core
// Turns display commands into three segment bytes in shift order.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on i_cmd (valid/ready). Each transfer yields exactly one
// result transfer on o_seg carrying the three bytes for the shift chain.
// The layout register at byte address 0 of the APB port selects the wiring;
// the user must write it only while no command is in flight; the block
// itself does not enforce this. A command passes through the input register,
// then through the decimal split and glyph lookup into the result register.
// Throughput is one command per cycle while o_seg is not stalled; the path
// is bounded by the constant-reciprocal multipliers of the decimal split.
// When the receiver stalls, the result register holds its bytes and the
// input register still takes one more command, after which i_cmd.ready
// drops until o_seg moves again.
// Reset empties both registers, sets the layout to reversed digits with the
// top bar in the LSB, and sets the remembered characters to blanks with no
// point.
// ----------------------------------------------------------------------------
module three_digit_seven_segment_formatter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tdsf_cmd_if.sink                      i_cmd,
    tdsf_seg_if.source                    o_seg,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdsf_pkg::PADDR_W-1:0]  paddr,
    input  logic [tdsf_pkg::PDATA_W-1:0]  pwdata,
    output logic [tdsf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Configuration and history state.
    logic               r_layout;
    logic [7:0]         r_last_chars [3];
    logic [1:0]         r_last_point;

    // Input register.
    logic               r_s1_valid;
    logic [1:0]         r_op;
    logic [7:0]         r_char_a;
    logic [7:0]         r_char_b;
    logic [7:0]         r_char_c;
    logic [15:0]        r_number;
    logic               r_zero_pad;
    logic [1:0]         r_point;

    // Result register.
    logic               r_out_valid;
    logic [7:0]         r_first;
    logic [7:0]         r_second;
    logic [7:0]         r_third;

    // Handshake control.
    logic               w_out_free;
    logic               w_s1_adv;
    logic               w_in_ready;
    logic               w_cfg_write;

    // Decimal split.
    logic               w_neg;
    logic [15:0]        w_mag;
    logic [32:0]        w_p10;
    logic [30:0]        w_p100;
    logic [31:0]        w_p1000;
    logic [13:0]        w_q10;
    logic [9:0]         w_q100;
    logic [6:0]         w_q1000;
    logic [16:0]        w_ones_full;
    logic [13:0]        w_tens_full;
    logic [9:0]         w_hund_full;
    logic [7:0]         w_ones;
    logic [7:0]         w_tens;
    logic [7:0]         w_hund;

    // Formatting results.
    logic [7:0]         n_c1;
    logic [7:0]         n_c2;
    logic [7:0]         n_c3;
    logic [1:0]         n_pt;
    logic [7:0]         w_d0;
    logic [7:0]         w_d1;
    logic [7:0]         w_d2;
    logic [7:0]         n_first;
    logic [7:0]         n_second;
    logic [7:0]         n_third;

    // Pipeline handshake: the input register moves on whenever the result
    // register is empty or being emptied.
    assign w_out_free = !r_out_valid || o_seg.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign w_in_ready = !r_s1_valid || w_out_free;
    assign i_cmd.ready = w_in_ready;

    assign o_seg.valid          = r_out_valid;
    assign o_seg.first_shifted  = r_first;
    assign o_seg.second_shifted = r_second;
    assign o_seg.third_shifted  = r_third;

    // Register access; only one register, decoded on the word address bit.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite
                         && (paddr[2] == tdsf_pkg::CFG_IDX_LAYOUT);
    assign prdata      = (paddr[2] == tdsf_pkg::CFG_IDX_LAYOUT)
                         ? {{(tdsf_pkg::PDATA_W-1){1'b0}}, r_layout}
                         : '0;

    // Magnitude and its decimal digits through constant reciprocals.
    always_comb begin
        w_neg   = r_number[15];
        w_mag   = w_neg ? (16'd0 - r_number) : r_number;
        w_p10   = 33'(w_mag) * 33'(tdsf_pkg::RECIP10);
        w_p100  = 31'(w_mag) * 31'(tdsf_pkg::RECIP100);
        w_p1000 = 32'(w_mag) * 32'(tdsf_pkg::RECIP1000);
        w_q10   = w_p10[32:tdsf_pkg::SHIFT10];
        w_q100  = w_p100[30:tdsf_pkg::SHIFT100];
        w_q1000 = w_p1000[31:tdsf_pkg::SHIFT1000];
        w_ones_full = 17'(w_mag) - (17'({w_q10, 3'b000}) + 17'({w_q10, 1'b0}));
        w_tens_full = w_q10 - (14'({w_q100, 3'b000}) + 14'({w_q100, 1'b0}));
        w_hund_full = w_q100 - (10'({w_q1000, 3'b000}) + 10'({w_q1000, 1'b0}));
        w_ones  = {4'd0, w_ones_full[3:0]};
        w_tens  = {4'd0, w_tens_full[3:0]};
        w_hund  = {4'd0, w_hund_full[3:0]};
    end

    // Character selection per command.
    always_comb begin
        n_c1 = r_last_chars[0];
        n_c2 = r_last_chars[1];
        n_c3 = r_last_chars[2];
        n_pt = r_last_point;
        case (tdsf_pkg::t_op'(r_op))
            tdsf_pkg::OP_CHARS: begin
                n_c1 = r_char_a;
                n_c2 = r_char_b;
                n_c3 = r_char_c;
                n_pt = r_point;
            end
            tdsf_pkg::OP_NUMBER: begin
                n_pt = tdsf_pkg::PT_NONE;
                n_c3 = w_ones;
                n_c2 = (!r_zero_pad && w_mag < 16'd10) ? tdsf_pkg::CODE_BLANK : w_tens;
                if (w_neg) begin
                    n_c1 = tdsf_pkg::CODE_MINUS;
                end else begin
                    n_c1 = (!r_zero_pad && w_mag < 16'd100)
                           ? tdsf_pkg::CODE_BLANK : w_hund;
                end
            end
            tdsf_pkg::OP_SETTING: begin
                n_pt = tdsf_pkg::PT_NONE;
                if ((w_neg && w_mag > 16'd9) || (!w_neg && w_mag > 16'd99)) begin
                    n_c1 = tdsf_pkg::CODE_E;
                    n_c2 = tdsf_pkg::CODE_R;
                    n_c3 = tdsf_pkg::CODE_R;
                end else if (w_neg) begin
                    n_c1 = r_char_a;
                    n_c2 = tdsf_pkg::CODE_MINUS;
                    n_c3 = w_ones;
                end else if (w_mag < 16'd10) begin
                    n_c1 = r_char_a;
                    n_c2 = r_zero_pad ? tdsf_pkg::CODE_ZERO : tdsf_pkg::CODE_BLANK;
                    n_c3 = w_ones;
                end else begin
                    n_c1 = r_char_a;
                    n_c2 = w_tens;
                    n_c3 = w_ones;
                end
            end
            tdsf_pkg::OP_REPEAT: begin
                n_c1 = r_last_chars[0];
            end
            default: begin
                n_c1 = r_last_chars[0];
            end
        endcase
    end

    // Glyph lookup, digit order, decimal point and bit order.
    always_comb begin
        w_d0 = tdsf_pkg::glyph(r_layout ? n_c3 : n_c1);
        w_d1 = tdsf_pkg::glyph(n_c2);
        w_d2 = tdsf_pkg::glyph(r_layout ? n_c1 : n_c3);
        if (n_pt == tdsf_pkg::PT_FIRST) begin
            w_d0 = w_d0 | tdsf_pkg::S_DP;
        end
        if (n_pt == tdsf_pkg::PT_SECOND) begin
            w_d1 = w_d1 | tdsf_pkg::S_DP;
        end
        if (n_pt == tdsf_pkg::PT_THIRD) begin
            w_d2 = w_d2 | tdsf_pkg::S_DP;
        end
        n_first  = r_layout ? w_d0 : tdsf_pkg::reverse8(w_d0);
        n_second = r_layout ? w_d1 : tdsf_pkg::reverse8(w_d1);
        n_third  = r_layout ? w_d2 : tdsf_pkg::reverse8(w_d2);
    end

    // Control state, layout register and display history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_layout     <= tdsf_pkg::LAYOUT_RESET;
            r_last_chars <= '{tdsf_pkg::CODE_BLANK, tdsf_pkg::CODE_BLANK,
                               tdsf_pkg::CODE_BLANK};
            r_last_point <= tdsf_pkg::PT_NONE;
        end else begin
            if (w_in_ready) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_cfg_write) begin
                r_layout <= pwdata[0];
            end
            if (w_s1_adv) begin
                r_last_chars <= '{n_c1, n_c2, n_c3};
                r_last_point <= n_pt;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && w_in_ready) begin
            r_op       <= i_cmd.operation;
            r_char_a   <= i_cmd.char_a;
            r_char_b   <= i_cmd.char_b;
            r_char_c   <= i_cmd.char_c;
            r_number   <= i_cmd.number;
            r_zero_pad <= i_cmd.zero_pad;
            r_point    <= i_cmd.point_position;
        end
        if (w_s1_adv) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end

endmodule

// ----- src/tdsf_checker.sv -----
// ----------------------------------------------------------------------------
// tdsf_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_first,
    input logic [7:0] i_out_second,
    input logic [7:0] i_out_third
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && i_in_ready;

    // A rising result follows the command transfer that caused it, through the input and result registers.
    `TDSF_ASSERT(a_result_latency, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(w_in_xfer, 2))

    // With no result pending, the block always takes a command.
    `TDSF_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)

    // A stalled result holds its bytes.
    `TDSF_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_first) && $stable(i_out_second) && $stable(i_out_third)))

    // Reset leaves no result pending.
    `TDSF_ASSERT_NR(a_reset_empty, i_clk, !$past(i_rst_n) |-> !i_out_valid)

endmodule

bind three_digit_seven_segment_formatter_core tdsf_checker u_tdsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_seg.valid),
    .i_out_ready  (o_seg.ready),
    .i_out_first  (o_seg.first_shifted),
    .i_out_second (o_seg.second_shifted),
    .i_out_third  (o_seg.third_shifted)
);
